// File: sv/tridiagonal_thomas_solver_assert.svh
// Assertion macros used by the solver's top-level RTL.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_ASSERT_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("solver assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("solver assertion failed");

`endif

// File: sv/tts_pkg.sv
package tts_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int FRAC_BITS  = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IN_WIDTH   = 32;
   localparam int IDX_WIDTH  = 6;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_PIVOT = 2'd1,
      ERR_ROWS  = 2'd2,
      ERR_SAT   = 2'd3
   } err_type;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] sub_diag;
      logic signed [IN_WIDTH-1:0] main_diag;
      logic signed [IN_WIDTH-1:0] super_diag;
      logic signed [IN_WIDTH-1:0] rhs;
      logic                       last_row;
   } req_type;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] solution;
      logic [IDX_WIDTH-1:0]       row_index;
      logic                       final_res;
      logic [1:0]                 error;
   } rsp_type;

   // Head of the row queue as seen by the back end.
   typedef struct packed {
      logic valid;
      logic last;
      logic sat_in;
   } queue_stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_G,
      S_MUL_U,
      S_PIVOT,
      S_DIV_G,
      S_DIV_U,
      S_STORE,
      S_BACK,
      S_BS_RD,
      S_BS_WAIT,
      S_BS_MUL,
      S_EM_RD,
      S_EM_OUT
   } back_state_type;

endpackage

// File: sv/tts_ram.sv
module tts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/tts_front.sv
module tts_front #(
   parameter int DATA_WIDTH = tts_pkg::DATA_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  tts_pkg::req_type              req_data,
   input  logic                          pop,
   output tts_pkg::queue_stat_type       stat,
   output logic signed [DATA_WIDTH-1:0]  a_out,
   output logic signed [DATA_WIDTH-1:0]  b_out,
   output logic signed [DATA_WIDTH-1:0]  c_out,
   output logic signed [DATA_WIDTH-1:0]  d_out
);

   localparam int IW = tts_pkg::IN_WIDTH;
   localparam int XW = (DATA_WIDTH > IW) ? DATA_WIDTH : IW;
   localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // Returns the saturation flag above the clamped value.
   function automatic logic [DATA_WIDTH:0] clamp_in(input logic signed [IW-1:0] x);
      logic signed [XW-1:0]         xe;
      logic signed [DATA_WIDTH-1:0] t;
      xe = XW'(x);
      t  = DATA_WIDTH'(xe);
      if (XW'(t) == xe) begin
         return {1'b0, t};
      end
      return {1'b1, x[IW-1] ? VMIN : VMAX};
   endfunction

   logic signed [DATA_WIDTH-1:0] a_ff [2];
   logic signed [DATA_WIDTH-1:0] b_ff [2];
   logic signed [DATA_WIDTH-1:0] c_ff [2];
   logic signed [DATA_WIDTH-1:0] d_ff [2];
   logic                         last_ff [2];
   logic                         sat_ff [2];
   logic                         wr_ptr_ff, wr_ptr_in;
   logic                         rd_ptr_ff, rd_ptr_in;
   logic [1:0]                   fill_ff, fill_in;

   logic [DATA_WIDTH:0] ca, cb, cc, cd;
   logic                push;

   assign ca = clamp_in(req_data.sub_diag);
   assign cb = clamp_in(req_data.main_diag);
   assign cc = clamp_in(req_data.super_diag);
   assign cd = clamp_in(req_data.rhs);

   assign busy = (fill_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         a_ff[wr_ptr_ff]    <= ca[DATA_WIDTH-1:0];
         b_ff[wr_ptr_ff]    <= cb[DATA_WIDTH-1:0];
         c_ff[wr_ptr_ff]    <= cc[DATA_WIDTH-1:0];
         d_ff[wr_ptr_ff]    <= cd[DATA_WIDTH-1:0];
         last_ff[wr_ptr_ff] <= req_data.last_row;
         sat_ff[wr_ptr_ff]  <= ca[DATA_WIDTH] | cb[DATA_WIDTH] | cc[DATA_WIDTH] | cd[DATA_WIDTH];
      end
   end

   always_comb begin
      stat.valid  = (fill_ff != 2'd0);
      stat.last   = last_ff[rd_ptr_ff];
      stat.sat_in = sat_ff[rd_ptr_ff];
      a_out       = a_ff[rd_ptr_ff];
      b_out       = b_ff[rd_ptr_ff];
      c_out       = c_ff[rd_ptr_ff];
      d_out       = d_ff[rd_ptr_ff];
   end

endmodule

// File: sv/tts_mul.sv
module tts_mul #(
   parameter int DATA_WIDTH = tts_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = tts_pkg::FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] x,
   input  logic signed [DATA_WIDTH-1:0] y,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] res,
   output logic                         sat
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int CNTW = $clog2(DATA_WIDTH + 1);
   localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [PW-1:0] POS_LIM = PW'(VMAX);
   localparam logic [PW-1:0] NEG_LIM = PW'(VMIN);

   logic [PW-1:0]         p_ff, p_in;
   logic [DATA_WIDTH-1:0] ma_ff, ma_in;
   logic                  neg_ff, neg_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [DATA_WIDTH:0]   sum;
   logic [PW-1:0]         sh;

   // Shift-and-add over magnitudes, one multiplier bit a cycle.
   always_comb begin
      sum     = {1'b0, p_ff[PW-1:DATA_WIDTH]} + {1'b0, ma_ff};
      p_in    = p_ff;
      ma_in   = ma_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         ma_in  = x[DATA_WIDTH-1] ? DATA_WIDTH'(-x) : DATA_WIDTH'(x);
         p_in   = {{DATA_WIDTH{1'b0}}, (y[DATA_WIDTH-1] ? DATA_WIDTH'(-y) : DATA_WIDTH'(y))};
         neg_in = x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1];
         cnt_in = CNTW'(DATA_WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         p_in   = p_ff[0] ? {sum, p_ff[DATA_WIDTH-1:1]} : {1'b0, p_ff[PW-1:1]};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      p_ff   <= p_in;
      ma_ff  <= ma_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      sh = p_ff >> FRAC_BITS;
      if (!neg_ff) begin
         sat = (sh > POS_LIM);
         res = sat ? VMAX : sh[DATA_WIDTH-1:0];
      end else begin
         sat = (sh > NEG_LIM);
         res = sat ? VMIN : DATA_WIDTH'(-sh[DATA_WIDTH-1:0]);
      end
   end

   assign done = done_ff;

endmodule

// File: sv/tts_div.sv
module tts_div #(
   parameter int DATA_WIDTH = tts_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = tts_pkg::FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] num,
   input  logic signed [DATA_WIDTH-1:0] den,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] res,
   output logic                         sat
);

   localparam int NW = DATA_WIDTH + FRAC_BITS;
   localparam int CNTW = $clog2(NW + 1);
   localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [NW-1:0] POS_LIM = NW'(VMAX);
   localparam logic [NW-1:0] NEG_LIM = NW'(VMIN);

   logic [NW-1:0]         num_ff, num_in;
   logic [NW-1:0]         q_ff, q_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dm_ff, dm_in;
   logic                  neg_ff, neg_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [DATA_WIDTH:0]   r2;
   logic                  ge;
   logic [DATA_WIDTH-1:0] nm;

   // Restoring division, one quotient bit a cycle.
   always_comb begin
      nm      = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : DATA_WIDTH'(num);
      r2      = {rem_ff, num_ff[NW-1]};
      ge      = (r2 >= {1'b0, dm_ff});
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dm_in   = dm_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = NW'(nm) << FRAC_BITS;
         q_in   = '0;
         rem_in = '0;
         dm_in  = den[DATA_WIDTH-1] ? DATA_WIDTH'(-den) : DATA_WIDTH'(den);
         neg_in = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
         cnt_in = CNTW'(NW);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? DATA_WIDTH'(r2 - {1'b0, dm_ff}) : r2[DATA_WIDTH-1:0];
         q_in   = {q_ff[NW-2:0], ge};
         num_in = num_ff << 1;
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dm_ff  <= dm_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (!neg_ff) begin
         sat = (q_ff > POS_LIM);
         res = sat ? VMAX : q_ff[DATA_WIDTH-1:0];
      end else begin
         sat = (q_ff > NEG_LIM);
         res = sat ? VMIN : DATA_WIDTH'(-q_ff[DATA_WIDTH-1:0]);
      end
   end

   assign done = done_ff;

endmodule

// File: sv/tts_back.sv
module tts_back #(
   parameter int MAX_ROWS   = tts_pkg::MAX_ROWS,
   parameter int FRAC_BITS  = tts_pkg::FRAC_BITS,
   parameter int DATA_WIDTH = tts_pkg::DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tts_pkg::queue_stat_type      stat,
   input  logic signed [DATA_WIDTH-1:0] a_in_q,
   input  logic signed [DATA_WIDTH-1:0] b_in_q,
   input  logic signed [DATA_WIDTH-1:0] c_in_q,
   input  logic signed [DATA_WIDTH-1:0] d_in_q,
   output logic                         pop,
   output logic                         rsp_valid,
   output tts_pkg::rsp_type             rsp_data
);

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = $clog2(MAX_ROWS + 1);
   localparam int XW = (AW > tts_pkg::IDX_WIDTH) ? AW : tts_pkg::IDX_WIDTH;
   localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // Saturating difference, overflow flag above the value.
   function automatic logic [DATA_WIDTH:0] sat_sub(input logic signed [DATA_WIDTH-1:0] x,
                                                   input logic signed [DATA_WIDTH-1:0] y);
      logic [DATA_WIDTH:0] diff;
      diff = {x[DATA_WIDTH-1], x} - {y[DATA_WIDTH-1], y};
      if (diff[DATA_WIDTH] != diff[DATA_WIDTH-1]) begin
         return {1'b1, diff[DATA_WIDTH] ? VMIN : VMAX};
      end
      return {1'b0, diff[DATA_WIDTH-1:0]};
   endfunction

   tts_pkg::back_state_type      state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   tts_pkg::err_type             err_ff, err_in;
   logic signed [DATA_WIDTH-1:0] a_ff, a_in;
   logic signed [DATA_WIDTH-1:0] b_ff, b_in;
   logic signed [DATA_WIDTH-1:0] c_ff, c_in;
   logic signed [DATA_WIDTH-1:0] d_ff, d_in;
   logic signed [DATA_WIDTH-1:0] g_ff, g_in;
   logic signed [DATA_WIDTH-1:0] u_ff, u_in;
   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic                         last_ff, last_in;
   logic [AW-1:0]                k_ff, k_in;

   logic                         mul_start, mul_done, mul_sat;
   logic signed [DATA_WIDTH-1:0] mul_x, mul_y, mul_res;
   logic                         div_start, div_done, div_sat;
   logic signed [DATA_WIDTH-1:0] div_n, div_res;

   logic                         g_we, u_we, rd_en;
   logic [AW-1:0]                wr_addr;
   logic [DATA_WIDTH-1:0]        u_wr;
   logic [DATA_WIDTH-1:0]        g_rd, u_rd;
   logic [DATA_WIDTH:0]          diff;
   logic [XW-1:0]                row_wide;

   tts_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .x(mul_x), .y(mul_y),
      .done(mul_done), .res(mul_res), .sat(mul_sat)
   );

   tts_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_n), .den(b_ff),
      .done(div_done), .res(div_res), .sat(div_sat)
   );

   tts_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ROWS)) u_ratio_ram (
      .clock(clock), .wr_en(g_we), .wr_addr(wr_addr), .wr_data(g_ff),
      .rd_en(rd_en), .rd_addr(k_ff), .rd_data(g_rd)
   );

   tts_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ROWS)) u_partial_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(wr_addr), .wr_data(u_wr),
      .rd_en(rd_en), .rd_addr(k_ff), .rd_data(u_rd)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      g_in      = g_ff;
      u_in      = u_ff;
      x_in      = x_ff;
      last_in   = last_ff;
      k_in      = k_ff;
      pop       = 1'b0;
      mul_start = 1'b0;
      mul_x     = a_ff;
      mul_y     = g_ff;
      div_start = 1'b0;
      div_n     = c_ff;
      g_we      = 1'b0;
      u_we      = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      u_wr      = u_ff;
      rd_en     = 1'b0;
      rsp_valid = 1'b0;
      diff      = '0;
      row_wide  = XW'(k_ff);
      rsp_data.solution  = tts_pkg::IN_WIDTH'(signed'(u_rd));
      rsp_data.row_index = row_wide[tts_pkg::IDX_WIDTH-1:0];
      rsp_data.final_res = (k_ff == '0);
      rsp_data.error     = err_ff;

      // The first error noted in a run is the one reported; later ones are ignored.
      unique case (state_ff)
         tts_pkg::S_IDLE: begin
            if (stat.valid) begin
               pop     = 1'b1;
               last_in = stat.last;
               if (count_ff == CW'(MAX_ROWS)) begin
                  if (err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_ROWS;
                  state_in = stat.last ? tts_pkg::S_BACK : tts_pkg::S_IDLE;
               end else begin
                  if (stat.sat_in && err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_SAT;
                  a_in = a_in_q;
                  b_in = b_in_q;
                  c_in = c_in_q;
                  d_in = d_in_q;
                  if (count_ff == '0) begin
                     state_in = tts_pkg::S_PIVOT;
                  end else begin
                     mul_start = 1'b1;
                     mul_x     = a_in_q;
                     mul_y     = g_ff;
                     state_in  = tts_pkg::S_MUL_G;
                  end
               end
            end
         end
         tts_pkg::S_MUL_G: begin
            if (mul_done) begin
               if (mul_sat && err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_SAT;
               diff = sat_sub(b_ff, mul_res);
               if (diff[DATA_WIDTH] && err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_SAT;
               b_in      = diff[DATA_WIDTH-1:0];
               mul_start = 1'b1;
               mul_x     = a_ff;
               mul_y     = u_ff;
               state_in  = tts_pkg::S_MUL_U;
            end
         end
         tts_pkg::S_MUL_U: begin
            if (mul_done) begin
               if (mul_sat && err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_SAT;
               diff = sat_sub(d_ff, mul_res);
               if (diff[DATA_WIDTH] && err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_SAT;
               d_in     = diff[DATA_WIDTH-1:0];
               state_in = tts_pkg::S_PIVOT;
            end
         end
         tts_pkg::S_PIVOT: begin
            if (b_ff == '0) begin
               if (err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_PIVOT;
               g_in     = '0;
               u_in     = '0;
               state_in = tts_pkg::S_STORE;
            end else begin
               div_start = 1'b1;
               div_n     = c_ff;
               state_in  = tts_pkg::S_DIV_G;
            end
         end
         tts_pkg::S_DIV_G: begin
            if (div_done) begin
               if (div_sat && err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_SAT;
               g_in      = div_res;
               div_start = 1'b1;
               div_n     = d_ff;
               state_in  = tts_pkg::S_DIV_U;
            end
         end
         tts_pkg::S_DIV_U: begin
            if (div_done) begin
               if (div_sat && err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_SAT;
               u_in     = div_res;
               state_in = tts_pkg::S_STORE;
            end
         end
         tts_pkg::S_STORE: begin
            g_we     = 1'b1;
            u_we     = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = last_ff ? tts_pkg::S_BACK : tts_pkg::S_IDLE;
         end
         tts_pkg::S_BACK: begin
            // The last row's u is still held and is its own solution.
            x_in = u_ff;
            if (count_ff == CW'(1)) begin
               k_in     = '0;
               state_in = tts_pkg::S_EM_RD;
            end else begin
               k_in     = AW'(count_ff - CW'(2));
               state_in = tts_pkg::S_BS_RD;
            end
         end
         tts_pkg::S_BS_RD: begin
            rd_en    = 1'b1;
            state_in = tts_pkg::S_BS_WAIT;
         end
         tts_pkg::S_BS_WAIT: begin
            mul_start = 1'b1;
            mul_x     = g_rd;
            mul_y     = x_ff;
            state_in  = tts_pkg::S_BS_MUL;
         end
         tts_pkg::S_BS_MUL: begin
            if (mul_done) begin
               if (mul_sat && err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_SAT;
               diff = sat_sub(u_rd, mul_res);
               if (diff[DATA_WIDTH] && err_in == tts_pkg::ERR_NONE) err_in = tts_pkg::ERR_SAT;
               x_in    = diff[DATA_WIDTH-1:0];
               u_we    = 1'b1;
               wr_addr = k_ff;
               u_wr    = diff[DATA_WIDTH-1:0];
               if (k_ff == '0) begin
                  k_in     = AW'(count_ff - CW'(1));
                  state_in = tts_pkg::S_EM_RD;
               end else begin
                  k_in     = k_ff - AW'(1);
                  state_in = tts_pkg::S_BS_RD;
               end
            end
         end
         tts_pkg::S_EM_RD: begin
            rd_en    = 1'b1;
            state_in = tts_pkg::S_EM_OUT;
         end
         tts_pkg::S_EM_OUT: begin
            rsp_valid = 1'b1;
            if (k_ff == '0) begin
               count_in = '0;
               err_in   = tts_pkg::ERR_NONE;
               state_in = tts_pkg::S_IDLE;
            end else begin
               k_in     = k_ff - AW'(1);
               state_in = tts_pkg::S_EM_RD;
            end
         end
         default: begin
            state_in = tts_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tts_pkg::S_IDLE;
         count_ff <= '0;
         err_ff   <= tts_pkg::ERR_NONE;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      g_ff    <= g_in;
      u_ff    <= u_in;
      x_ff    <= x_in;
      last_ff <= last_in;
      k_ff    <= k_in;
   end

endmodule

// File: sv/tridiagonal_thomas_solver.sv
// Tridiagonal solver by the Thomas algorithm. Rows are written with start while busy is
// low and wait in a two-row queue; busy rises only when that queue is full. The forward
// sweep works on each row with the bit-serial multiplier and the restoring divider, one bit
// a cycle each; row 0 skips the two products. The row marked last then starts back
// substitution, after which the solutions leave highest row first, each valid on rsp_valid
// for exactly one cycle. The receiver cannot stall the block, so results must be taken as
// they appear.
`include "tridiagonal_thomas_solver_assert.svh"

module tridiagonal_thomas_solver #(
   parameter int MAX_ROWS   = tts_pkg::MAX_ROWS,
   parameter int FRAC_BITS  = tts_pkg::FRAC_BITS,
   parameter int DATA_WIDTH = tts_pkg::DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   output tts_pkg::rsp_type rsp_data
);

   tts_pkg::queue_stat_type      stat;
   logic                         pop;
   logic signed [DATA_WIDTH-1:0] a_q, b_q, c_q, d_q;

   tts_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .pop(pop), .stat(stat), .a_out(a_q), .b_out(b_q), .c_out(c_q), .d_out(d_q)
   );

   tts_back #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock(clock), .reset(reset), .stat(stat), .a_in_q(a_q), .b_in_q(b_q),
      .c_in_q(c_q), .d_in_q(d_q), .pop(pop), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   `TTS_ASSERT_NOW(a_final_is_row_zero, clock, reset, rsp_valid && rsp_data.final_res, rsp_data.row_index == '0)
   `TTS_ASSERT_NEXT(a_final_ends_run, clock, reset, rsp_valid && rsp_data.final_res, !rsp_valid)
   `TTS_ASSERT_NOW(a_busy_has_rows, clock, reset, busy, stat.valid)
   `TTS_ASSERT_NEXT(a_pop_while_idle, clock, reset, pop, !rsp_valid)

endmodule

// File: tb/tridiagonal_thomas_solver_tb.sv
module tridiagonal_thomas_solver_tb;

   localparam int STALL_LIMIT = 20000;
   localparam longint POS_MAX = 64'sd2147483647;

   // Predicts the solutions of each system and holds them until they are emitted.
   class solution_board;
      longint ratio_mem[tts_pkg::MAX_ROWS];
      longint partial_mem[tts_pkg::MAX_ROWS];
      int rows;
      tts_pkg::err_type err_code;
      tts_pkg::rsp_type pending[$];
      int fails;

      function new();
         rows = 0;
         err_code = tts_pkg::ERR_NONE;
         fails = 0;
      endfunction

      function void report(string what);
         $display("mismatch: %s", what);
         fails++;
      endfunction

      function void note(tts_pkg::err_type code);
         if (err_code == tts_pkg::ERR_NONE) err_code = code;
      endfunction

      function longint unsigned magnitude(longint x);
         return x < 0 ? longint'(-x) : x;
      endfunction

      function longint from_mag(bit neg, longint unsigned m);
         if (!neg) begin
            if (m > POS_MAX) begin
               note(tts_pkg::ERR_SAT);
               m = POS_MAX;
            end
            return longint'(m);
         end
         if (m > POS_MAX + 1) begin
            note(tts_pkg::ERR_SAT);
            m = POS_MAX + 1;
         end
         return -longint'(m);
      endfunction

      function longint sat_sub(longint x, longint y);
         longint s;
         s = x - y;
         return from_mag(s < 0, magnitude(s));
      endfunction

      function longint fx_mul(longint x, longint y);
         longint unsigned p;
         p = magnitude(x) * magnitude(y);
         return from_mag((x < 0) != (y < 0), p >> tts_pkg::FRAC_BITS);
      endfunction

      function longint fx_div(longint n, longint d);
         longint unsigned q;
         q = (magnitude(n) << tts_pkg::FRAC_BITS) / magnitude(d);
         return from_mag((n < 0) != (d < 0), q);
      endfunction

      function void note_row(tts_pkg::req_type r);
         longint a, b, c, d, v, g, u;
         tts_pkg::rsp_type e;
         if (rows < tts_pkg::MAX_ROWS) begin
            a = longint'(r.sub_diag);
            b = longint'(r.main_diag);
            c = longint'(r.super_diag);
            d = longint'(r.rhs);
            g = 0;
            u = 0;
            if (rows == 0) begin
               v = b;
            end else begin
               v = sat_sub(b, fx_mul(a, ratio_mem[rows-1]));
               d = sat_sub(d, fx_mul(a, partial_mem[rows-1]));
            end
            if (v == 0) begin
               note(tts_pkg::ERR_PIVOT);
            end else begin
               g = fx_div(c, v);
               u = fx_div(d, v);
            end
            ratio_mem[rows] = g;
            partial_mem[rows] = u;
            rows++;
         end else begin
            note(tts_pkg::ERR_ROWS);
         end
         if (!r.last_row) return;
         for (int k = rows - 2; k >= 0; k--)
            partial_mem[k] = sat_sub(partial_mem[k], fx_mul(ratio_mem[k], partial_mem[k+1]));
         for (int k = rows - 1; k >= 0; k--) begin
            e.solution  = 32'(partial_mem[k]);
            e.row_index = 6'(k);
            e.final_res = (k == 0);
            e.error     = err_code;
            pending.push_back(e);
         end
         rows = 0;
         err_code = tts_pkg::ERR_NONE;
      endfunction

      function void check(tts_pkg::rsp_type got);
         tts_pkg::rsp_type w;
         if (pending.size() == 0) begin
            report($sformatf("unexpected solution for row %0d", got.row_index));
            return;
         end
         w = pending.pop_front();
         if (got.solution !== w.solution)
            report($sformatf("row %0d solution %h, wanted %h", w.row_index, got.solution,
                             w.solution));
         if (got.row_index !== w.row_index)
            report($sformatf("row index %0d, wanted %0d", got.row_index, w.row_index));
         if (got.final_res !== w.final_res)
            report($sformatf("row %0d final flag %b, wanted %b", w.row_index, got.final_res,
                             w.final_res));
         if (got.error !== w.error)
            report($sformatf("row %0d error %0d, wanted %0d", w.row_index, got.error, w.error));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   tts_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_valid;
   tts_pkg::rsp_type rsp_data;

   solution_board board = new();
   int      stall_count = 0;
   int      items_sent = 0;
   int      idle_pct = 12;

   tridiagonal_thomas_solver i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("[tridiagonal_thomas_solver] ERROR");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at a falling edge with start low.
   task automatic send_row(tts_pkg::req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      board.note_row(r);
      items_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   function automatic int rand_sign(int unsigned m);
      return $urandom_range(1) ? -int'(m) : int'(m);
   endfunction

   // A well-formed system is diagonally dominant; noise rows use every bit pattern.
   task automatic send_system(int n, bit noisy);
      tts_pkg::req_type r;
      for (int i = 0; i < n; i++) begin
         if (noisy) begin
            r.sub_diag   = $urandom;
            r.main_diag  = $urandom;
            r.super_diag = $urandom;
            r.rhs        = $urandom;
         end else begin
            r.sub_diag   = rand_sign($urandom_range(0, 3 << 16));
            r.main_diag  = rand_sign($urandom_range(8 << 16, 40 << 16));
            r.super_diag = rand_sign($urandom_range(0, 3 << 16));
            r.rhs        = rand_sign($urandom_range(0, 1000 << 16));
         end
         r.last_row = (i == n - 1);
         send_row(r);
      end
   endtask

   task automatic send_fixed(int a, int b, int c, int d, bit last);
      tts_pkg::req_type r;
      r.sub_diag   = a;
      r.main_diag  = b;
      r.super_diag = c;
      r.rhs        = d;
      r.last_row   = last;
      send_row(r);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_pct = 0;
      send_fixed(0, 1 << 16, 0, 3 << 16, 1'b1);
      // A zero diagonal on the first row is a zero pivot.
      send_fixed(5, 0, 7, 9, 1'b1);
      // Extreme coefficients drive the arithmetic into saturation.
      send_fixed(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
      send_fixed(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
      send_fixed(32'shffffffff, 1, 32'sh7fffffff, 32'sh80000000, 1'b1);
      // The second row cancels its own pivot: b - a*g is exactly zero.
      send_fixed(0, 2 << 16, 2 << 16, 4 << 16, 1'b0);
      send_fixed(1 << 16, 1 << 16, 0, 1 << 16, 1'b1);
      send_fixed(0, 0, 0, 0, 1'b1);
      send_fixed(0, -(3 << 16), 32'sh7fffffff, -1, 1'b1);

      // Hold the next item back until the solver has emitted everything.
      while (board.pending.size() != 0) @(negedge clock);

      idle_pct = 12;
      // One row more than the store holds: the extra row is dropped but still ends the run.
      send_system(tts_pkg::MAX_ROWS + 1, 1'b0);
      while (items_sent < 120) begin
         if (items_sent > 100) idle_pct = 0;
         else if (items_sent > 80) idle_pct = 48;
         send_system($urandom_range(9) == 0 ? $urandom_range(6, 12) : $urandom_range(1, 4),
                     $urandom_range(9) < 3);
      end

      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.fails == 0)
         $display("[tridiagonal_thomas_solver] OK");
      else
         $display("[tridiagonal_thomas_solver] ERROR");
      $finish;
   end
endmodule

// File: files.f
+incdir+sv
sv/tts_pkg.sv
sv/tts_ram.sv
sv/tts_front.sv
sv/tts_mul.sv
sv/tts_div.sv
sv/tts_back.sv
sv/tridiagonal_thomas_solver.sv
tb/tridiagonal_thomas_solver_tb.sv
